### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define OWBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define OWBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define OWBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/owbm_pkg.sv
// Shared types and constants of the 1-Wire bus master.
// No dependencies; imported by every module and the testbench.
package owbm_pkg;

  localparam int BitsPerByte = 8;
  localparam int CntW        = 10;
  localparam int BitW        = 3;
  localparam int AddrW       = 5;
  localparam int DataW       = 32;

  typedef enum logic [1:0] {
    FuncTick  = 2'd0,
    FuncReset = 2'd1,
    FuncWrite = 2'd2,
    FuncRead  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhRstLow  = 3'd1,
    PhRstWait = 3'd2,
    PhRstTail = 3'd3,
    PhWrLow   = 3'd4,
    PhWrRel   = 3'd5,
    PhRdLow   = 3'd6,
    PhRdRel   = 3'd7
  } phase_e;

  // Register word indexes (byte address / 4)
  localparam logic [2:0] RegResetLow    = 3'd0;
  localparam logic [2:0] RegPresenceWait = 3'd1;
  localparam logic [2:0] RegResetTail   = 3'd2;
  localparam logic [2:0] RegSlot        = 3'd3;
  localparam logic [2:0] RegWriteOneLow = 3'd4;
  localparam logic [2:0] RegReadLow     = 3'd5;

  localparam logic [9:0] ResetLowRst     = 10'd480;
  localparam logic [7:0] PresenceWaitRst = 8'd80;
  localparam logic [9:0] ResetTailRst    = 10'd400;
  localparam logic [7:0] SlotRst         = 8'd60;
  localparam logic [3:0] WriteOneLowRst  = 4'd1;
  localparam logic [3:0] ReadLowRst      = 4'd2;

  typedef struct packed {
    logic [9:0] reset_low;
    logic [7:0] presence_wait;
    logic [9:0] reset_tail;
    logic [7:0] slot;
    logic [3:0] write_one_low;
    logic [3:0] read_low;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
    logic       rejected;
  } res_t;

endpackage

### rtl/owbm_if.sv
// Valid/ready channel interfaces for command words and result words.
// Depends on nothing but the field widths of the 1-Wire bus master.
interface owbm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] tx_byte;
  logic       line_level;

  modport source (output valid, output func, output tx_byte, output line_level, input ready);
  modport sink   (input valid, input func, input tx_byte, input line_level, output ready);
endinterface

interface owbm_res_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] rx_byte;
  logic       rejected;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence, output rx_byte, output rejected, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input presence, input rx_byte, input rejected, output ready);
endinterface

### rtl/one_wire_bus_master.sv
// 1-Wire bus master top level: input register, phase sequencer, result register.
// Depends on owbm_pkg, owbm_if, owbm_regs, owbm_core and assert_macros.svh.
// Usage:
//   cmd_i carries one word per tick or command: func 0 is a one-microsecond tick
//   with the sampled bus level, 1 starts a reset with presence detect, 2 writes
//   tx_byte and 3 reads a byte, both LSB first. res_o returns exactly one word
//   per accepted word, in order: drive_low for the following interval, busy,
//   done, the last presence result, the last read byte and the reject flag.
//   Commands that arrive while busy are rejected and the operation goes on.
// Timing:
//   A result passes the input register, then the result register, and can be taken
//   at the next edge. One word is taken every cycle unless the result side stalls;
//   the combinational sequencer update between the two registers sets the rate.
// Stall:
//   When the result consumer holds ready low, the result register holds its
//   word, the input register fills, and then cmd_i.ready drops. Nothing is lost.
// Reset:
//   rst_ni clears both pipeline valids, returns the sequencer to idle and loads
//   the default timing registers (480, 80, 400, 60, 1, 2 ticks).
// Configuration: APB writes to byte address 4*i; write only with no word in flight.
`include "assert_macros.svh"

module one_wire_bus_master (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  owbm_cmd_if.sink                    cmd_i,
  owbm_res_if.source                  res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [owbm_pkg::AddrW-1:0]  paddr,
  input  logic [owbm_pkg::DataW-1:0]  pwdata,
  output logic [owbm_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import owbm_pkg::*;

  cfg_t       cfg;
  res_t       res_d, res_q;
  logic       in_vld_q, res_vld_q;
  logic [1:0] in_func_q;
  logic [7:0] in_tx_q;
  logic       in_line_q;
  logic       adv, fire;

  // Advance when the result slot is free or being drained
  assign adv         = !res_vld_q || res_o.ready;
  assign fire        = in_vld_q && adv;
  assign cmd_i.ready = !in_vld_q || adv;

  owbm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register: hold the word until the sequencer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      in_func_q <= cmd_i.func;
      in_tx_q   <= cmd_i.tx_byte;
      in_line_q <= cmd_i.line_level;
    end
  end

  owbm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .fire_i       (fire),
    .func_i       (in_func_q),
    .tx_byte_i    (in_tx_q),
    .line_level_i (in_line_q),
    .res_o        (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
  end

  assign res_o.valid     = res_vld_q;
  assign res_o.drive_low = res_q.drive_low;
  assign res_o.busy_res  = res_q.busy_res;
  assign res_o.done_res  = res_q.done_res;
  assign res_o.presence  = res_q.presence;
  assign res_o.rx_byte   = res_q.rx_byte;
  assign res_o.rejected  = res_q.rejected;

  // A pulled-low bus always belongs to a running operation
  `OWBM_ASSERT_IMP(a_drive_busy, clk_i, rst_ni, res_vld_q && res_q.drive_low,
                   res_q.busy_res, "drive_low while not busy")
  // Finishing an operation leaves the sequencer idle
  `OWBM_ASSERT_IMP(a_done_idle, clk_i, rst_ni, res_vld_q && res_q.done_res,
                   !res_q.busy_res && !res_q.rejected, "done with busy or rejected")
  // A command is rejected only while an operation is running
  `OWBM_ASSERT_IMP(a_rej_busy, clk_i, rst_ni, res_vld_q && res_q.rejected,
                   res_q.busy_res, "rejected while idle")
  // A held input word is never dropped
  `OWBM_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_vld_q && !fire,
                    in_vld_q, "input word lost during stall")

endmodule

### rtl/owbm_regs.sv
// APB timing register file of the 1-Wire bus master.
// Depends on owbm_pkg for register indexes, reset values and cfg_t.
module owbm_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [owbm_pkg::AddrW-1:0]  paddr,
  input  logic [owbm_pkg::DataW-1:0]  pwdata,
  output logic [owbm_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output owbm_pkg::cfg_t              cfg_o
);
  import owbm_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low     <= ResetLowRst;
      cfg_q.presence_wait <= PresenceWaitRst;
      cfg_q.reset_tail    <= ResetTailRst;
      cfg_q.slot          <= SlotRst;
      cfg_q.write_one_low <= WriteOneLowRst;
      cfg_q.read_low      <= ReadLowRst;
    end else if (wr_en) begin
      unique case (idx)
        RegResetLow:     cfg_q.reset_low     <= pwdata[9:0];
        RegPresenceWait: cfg_q.presence_wait <= pwdata[7:0];
        RegResetTail:    cfg_q.reset_tail    <= pwdata[9:0];
        RegSlot:         cfg_q.slot          <= pwdata[7:0];
        RegWriteOneLow:  cfg_q.write_one_low <= pwdata[3:0];
        RegReadLow:      cfg_q.read_low      <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegResetLow:     prdata = DataW'(cfg_q.reset_low);
      RegPresenceWait: prdata = DataW'(cfg_q.presence_wait);
      RegResetTail:    prdata = DataW'(cfg_q.reset_tail);
      RegSlot:         prdata = DataW'(cfg_q.slot);
      RegWriteOneLow:  prdata = DataW'(cfg_q.write_one_low);
      RegReadLow:      prdata = DataW'(cfg_q.read_low);
      default:         prdata = '0;
    endcase
  end

endmodule

### rtl/owbm_core.sv
// Bus phase sequencer: holds the operation state and computes one result per word.
// Depends on owbm_pkg for phase_e, func_e, cfg_t and res_t.
module owbm_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  owbm_pkg::cfg_t cfg_i,
  input  logic           fire_i,
  input  logic [1:0]     func_i,
  input  logic [7:0]     tx_byte_i,
  input  logic           line_level_i,
  output owbm_pkg::res_t res_o
);
  import owbm_pkg::*;

  phase_e              phase_q, phase_d, ph_a;
  logic [CntW-1:0]     cnt_q, cnt_d, cnt_a, cnt_inc;
  logic [BitW-1:0]     bit_q, bit_d, bit_a, sel;
  logic [BitW:0]       bit_inc;
  logic [7:0]          shift_q, shift_d, shift_a;
  func_e               op_q, op_a;
  logic                pres_q, pres_a;
  logic [7:0]          rbyte_q, rbyte_d;
  logic                fin_a, fin_d, rej;
  logic                chain, found, slot_z, w1_z, cur, low_z_sel;
  logic [CntW-1:0]     low_dur, rel_dur;
  logic [BitsPerByte-1:0] skip_v, cand_v;

  // Phase register and operation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      op_q    <= FuncTick;
      pres_q  <= 1'b0;
      rbyte_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      op_q    <= op_a;
      pres_q  <= pres_a;
      rbyte_q <= rbyte_d;
    end
  end

  // Apply the word: tick, start or reject
  always_comb begin
    ph_a    = phase_q;
    cnt_a   = cnt_q;
    bit_a   = bit_q;
    shift_a = shift_q;
    op_a    = op_q;
    pres_a  = pres_q;
    fin_a   = 1'b0;
    rej     = 1'b0;
    cnt_inc = cnt_q + CntW'(1);
    bit_inc = {1'b0, bit_q} + (BitW+1)'(1);
    if (fire_i) begin
      if (func_e'(func_i) == FuncTick) begin
        unique case (phase_q)
          PhIdle: begin
          end
          PhRstWait: begin
            if (cnt_inc >= CntW'(cfg_i.presence_wait)) begin
              pres_a = ~line_level_i;
              ph_a   = PhRstTail;
              cnt_a  = '0;
            end else begin
              cnt_a = cnt_inc;
            end
          end
          PhRdRel: begin
            // sample on the first released tick
            if (cnt_q == '0) shift_a[bit_q] = shift_q[bit_q] | line_level_i;
            if (cnt_inc > CntW'(cfg_i.slot)) begin
              if (bit_inc >= (BitW+1)'(BitsPerByte)) begin
                ph_a  = PhIdle;
                cnt_a = '0;
                bit_a = '0;
                fin_a = 1'b1;
              end else begin
                ph_a  = PhRdLow;
                cnt_a = '0;
                bit_a = bit_inc[BitW-1:0];
              end
            end else begin
              cnt_a = cnt_inc;
            end
          end
          default: cnt_a = cnt_inc;
        endcase
      end else if (phase_q != PhIdle) begin
        rej = 1'b1;
      end else begin
        op_a  = func_e'(func_i);
        cnt_a = '0;
        bit_a = '0;
        unique case (func_e'(func_i))
          FuncReset: begin
            shift_a = '0;
            ph_a    = PhRstLow;
          end
          FuncWrite: begin
            shift_a = tx_byte_i;
            ph_a    = PhWrLow;
          end
          default: begin
            shift_a = '0;
            ph_a    = PhRdLow;
          end
        endcase
      end
    end
  end

  // Pass through timed phases that have run out; zero-length bits are skipped together
  always_comb begin
    slot_z  = (cfg_i.slot == '0);
    w1_z    = (cfg_i.write_one_low == '0);
    cur     = shift_a[bit_a];
    low_dur = cur ? CntW'(cfg_i.write_one_low) : CntW'(cfg_i.slot);
    rel_dur = cur ? CntW'(cfg_i.slot) : '0;
    for (int j = 0; j < BitsPerByte; j++) begin
      skip_v[j] = shift_a[j] ? (w1_z && slot_z) : slot_z;
      cand_v[j] = (j > int'(bit_a)) && !skip_v[j];
    end
    sel   = '0;
    found = 1'b0;
    for (int j = BitsPerByte - 1; j >= 0; j--) begin
      if (cand_v[j]) begin
        sel   = BitW'(j);
        found = 1'b1;
      end
    end
    low_z_sel = shift_a[sel] ? w1_z : slot_z;

    phase_d = ph_a;
    cnt_d   = cnt_a;
    bit_d   = bit_a;
    fin_d   = fin_a;
    chain   = 1'b0;
    unique case (ph_a)
      PhRstLow: begin
        if (cnt_a >= cfg_i.reset_low) begin
          phase_d = PhRstWait;
          cnt_d   = '0;
        end
      end
      PhRstTail: begin
        if (cnt_a >= cfg_i.reset_tail) begin
          phase_d = PhIdle;
          cnt_d   = '0;
          bit_d   = '0;
          fin_d   = 1'b1;
        end
      end
      PhRdLow: begin
        if (cnt_a >= CntW'(cfg_i.read_low)) begin
          phase_d = PhRdRel;
          cnt_d   = '0;
        end
      end
      PhWrLow: begin
        if (cnt_a >= low_dur) begin
          if (rel_dur == '0) begin
            chain = 1'b1;
          end else begin
            phase_d = PhWrRel;
            cnt_d   = '0;
          end
        end
      end
      PhWrRel: begin
        if (cnt_a >= rel_dur) chain = 1'b1;
      end
      default: begin
      end
    endcase

    if (chain) begin
      cnt_d = '0;
      if (found) begin
        bit_d   = sel;
        phase_d = low_z_sel ? PhWrRel : PhWrLow;
      end else begin
        bit_d   = '0;
        phase_d = PhIdle;
        fin_d   = 1'b1;
      end
    end

    shift_d = shift_a;
    rbyte_d = (fin_d && op_a == FuncRead) ? shift_a : rbyte_q;
  end

  always_comb begin
    res_o.drive_low = (phase_d == PhRstLow) || (phase_d == PhWrLow) || (phase_d == PhRdLow);
    res_o.busy_res  = (phase_d != PhIdle);
    res_o.done_res  = fin_d;
    res_o.presence  = pres_a;
    res_o.rx_byte   = rbyte_d;
    res_o.rejected  = rej;
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Testbench of the 1-Wire bus master: streams command and tick words, programs
// the slot timing over APB and checks every result word against a local sequencer.
// Depends on owbm_pkg, the owbm_cmd_if/owbm_res_if interfaces and one_wire_bus_master.
module testbench;
  import owbm_pkg::*;

  // Word indexes past the last timing register; writes there must change nothing.
  localparam logic [2:0] RegSpareA = 3'd6;
  localparam logic [2:0] RegSpareB = 3'd7;

  // Cycles without any word moving before the run is declared hung.
  localparam int unsigned StallLimit = 2000;
  // Settle time after the last result: two pipeline stages plus margin.
  localparam int unsigned DrainCycles = 8;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  owbm_cmd_if cmd_if ();
  owbm_res_if res_if ();

  one_wire_bus_master dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5ns clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Sequencer mirror: timing registers and bus state as the block should hold
  // them after every accepted command word.
  // ---------------------------------------------------------------------------
  cfg_t        ow_cfg;
  phase_e      ow_phase;
  int unsigned ow_ticks;
  logic [2:0]  ow_bit;
  logic [7:0]  ow_shift;
  func_e       ow_op;
  logic        ow_presence;
  logic [7:0]  ow_rx;
  logic        ow_done;

  res_t        bus_words_due[$];   // result words owed by the block, oldest first
  int unsigned faults;
  int unsigned useful_items;       // words that started or advanced an operation
  bit          sender_steady;      // no gaps between command words
  bit          sink_steady;        // no stalls on the result side
  int unsigned sink_hold;
  int unsigned quiet_cycles;

  function automatic void clear_sequencer();
    ow_cfg = '{reset_low: ResetLowRst, presence_wait: PresenceWaitRst,
               reset_tail: ResetTailRst, slot: SlotRst,
               write_one_low: WriteOneLowRst, read_low: ReadLowRst};
    ow_phase    = PhIdle;
    ow_ticks    = 0;
    ow_bit      = '0;
    ow_shift    = '0;
    ow_op       = FuncTick;
    ow_presence = 1'b0;
    ow_rx       = '0;
    ow_done     = 1'b0;
  endfunction

  // Length of the current timed phase; sampling phases and idle have none.
  function automatic bit phase_limit(output int unsigned limit);
    limit = 0;
    case (ow_phase)
      PhRstLow:  limit = ow_cfg.reset_low;
      PhRstTail: limit = ow_cfg.reset_tail;
      PhWrLow:   limit = ow_shift[ow_bit] ? ow_cfg.write_one_low : ow_cfg.slot;
      PhWrRel:   limit = ow_shift[ow_bit] ? ow_cfg.slot : 0;
      PhRdLow:   limit = ow_cfg.read_low;
      default:   return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void end_operation();
    if (ow_op == FuncRead) ow_rx = ow_shift;
    ow_phase = PhIdle;
    ow_ticks = 0;
    ow_bit   = '0;
    ow_done  = 1'b1;
  endfunction

  function automatic void next_slot(phase_e first);
    if (int'(ow_bit) + 1 >= BitsPerByte) begin
      end_operation();
    end else begin
      ow_bit   = ow_bit + 3'd1;
      ow_phase = first;
      ow_ticks = 0;
    end
  endfunction

  function automatic void leave_phase();
    ow_ticks = 0;
    case (ow_phase)
      PhRstLow:  ow_phase = PhRstWait;
      PhRstTail: end_operation();
      PhWrLow:   ow_phase = PhWrRel;
      PhWrRel:   next_slot(PhWrLow);
      PhRdLow:   ow_phase = PhRdRel;
      default:   ;
    endcase
  endfunction

  // Fall through every timed phase that has already expired, zero-length ones
  // included, so a write with all durations zero ends on its own command word.
  function automatic void run_out_timers();
    int unsigned limit;
    while (phase_limit(limit) && ow_ticks >= limit) leave_phase();
  endfunction

  // Advance the mirror by one command word and return the result word it owes.
  function automatic res_t next_bus_word(func_e f, logic [7:0] tx, logic lvl);
    res_t w;
    w = '0;
    ow_done = 1'b0;
    if (f == FuncTick) begin
      case (ow_phase)
        PhIdle: ;
        PhRstWait: begin
          // A zero wait still needs one tick before the presence sample.
          ow_ticks++;
          if (ow_ticks >= ow_cfg.presence_wait) begin
            ow_presence = ~lvl;
            ow_phase    = PhRstTail;
            ow_ticks    = 0;
            run_out_timers();
          end
        end
        PhRdRel: begin
          // Sample on the first released tick, then sit out the slot.
          if (ow_ticks == 0) ow_shift[ow_bit] = ow_shift[ow_bit] | lvl;
          ow_ticks++;
          if (ow_ticks > ow_cfg.slot) begin
            next_slot(PhRdLow);
            run_out_timers();
          end
        end
        default: begin
          ow_ticks = (ow_ticks + 1) % 1024;
          run_out_timers();
        end
      endcase
    end else if (ow_phase != PhIdle) begin
      // Commands while busy bounce; the running operation is untouched.
      w.rejected = 1'b1;
    end else begin
      ow_op    = f;
      ow_ticks = 0;
      ow_bit   = '0;
      case (f)
        FuncReset: begin
          ow_shift = '0;
          ow_phase = PhRstLow;
        end
        FuncWrite: begin
          ow_shift = tx;
          ow_phase = PhWrLow;
        end
        default: begin
          ow_shift = '0;
          ow_phase = PhRdLow;
        end
      endcase
      run_out_timers();
    end
    w.drive_low = (ow_phase == PhRstLow) || (ow_phase == PhWrLow) || (ow_phase == PhRdLow);
    w.busy_res  = (ow_phase != PhIdle);
    w.done_res  = ow_done;
    w.presence  = ow_presence;
    w.rx_byte   = ow_rx;
    return w;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Offer one word after a random gap, hold it until taken, then predict.
  task automatic send_word(func_e f, logic [7:0] tx, logic lvl);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.func       <= f;
    cmd_if.tx_byte    <= tx;
    cmd_if.line_level <= lvl;
    do @(posedge clk_i); while (!cmd_if.ready);
    // Idle ticks and bounced commands do nothing; count only the rest.
    if ((f == FuncTick) == (ow_phase != PhIdle)) useful_items++;
    bus_words_due.push_back(next_bus_word(f, tx, lvl));
  endtask

  // Drop valid and hold off until every owed result word has come back.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (bus_words_due.size() != 0) @(posedge clk_i);
  endtask

  // Start one operation and feed ticks until the mirror goes idle. With noise,
  // sprinkle bounced commands and the odd full pause into the slot stream.
  task automatic run_operation(func_e op, bit noisy);
    send_word(op, 8'($urandom), 1'($urandom));
    while (ow_phase != PhIdle) begin
      if (noisy && $urandom_range(0, 15) == 0)
        send_word(func_e'(2'($urandom_range(1, 3))), 8'($urandom), 1'($urandom));
      else if (noisy && $urandom_range(0, 39) == 0)
        drain_results();
      else
        send_word(FuncTick, 8'($urandom), 1'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // APB side; only used with nothing in flight
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegResetLow:     ow_cfg.reset_low     = val[9:0];
      RegPresenceWait: ow_cfg.presence_wait = val[7:0];
      RegResetTail:    ow_cfg.reset_tail    = val[9:0];
      RegSlot:         ow_cfg.slot          = val[7:0];
      RegWriteOneLow:  ow_cfg.write_one_low = val[3:0];
      RegReadLow:      ow_cfg.read_low      = val[3:0];
      default:         ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic read_reg(logic [2:0] idx, output logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    val = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_timing(cfg_t c);
    write_reg(RegResetLow,     DataW'(c.reset_low));
    write_reg(RegPresenceWait, DataW'(c.presence_wait));
    write_reg(RegResetTail,    DataW'(c.reset_tail));
    write_reg(RegSlot,         DataW'(c.slot));
    write_reg(RegWriteOneLow,  DataW'(c.write_one_low));
    write_reg(RegReadLow,      DataW'(c.read_low));
  endtask

  // Mostly short durations, with zero about a quarter of the time.
  function automatic int unsigned short_count(int unsigned hi);
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, hi);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, in-order compare against the owed words
  // ---------------------------------------------------------------------------
  task automatic take_result();
    res_t want;
    if (bus_words_due.size() == 0) begin
      $error("result word arrived with no command word outstanding");
      faults++;
      return;
    end
    want = bus_words_due.pop_front();
    check_field("drive_low", want.drive_low, res_if.drive_low);
    check_field("busy_res",  want.busy_res,  res_if.busy_res);
    check_field("done_res",  want.done_res,  res_if.done_res);
    check_field("presence",  want.presence,  res_if.presence);
    check_field("rx_byte",   want.rx_byte,   res_if.rx_byte);
    check_field("rejected",  want.rejected,  res_if.rejected);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        take_result();
        sink_hold = sink_steady ? 0 : $urandom_range(0, 5);
      end
      // Hold ready low for the drawn stall, then keep it high until a word moves.
      if (sink_hold > 0) begin
        res_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any word moving on either channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Read back the power-up timing.
  task automatic test_reset_defaults();
    logic [DataW-1:0] got;
    read_reg(RegResetLow, got);
    check_field("reset_low_ticks", ResetLowRst, got[9:0]);
    read_reg(RegPresenceWait, got);
    check_field("presence_wait_ticks", PresenceWaitRst, got[7:0]);
    read_reg(RegResetTail, got);
    check_field("reset_tail_ticks", ResetTailRst, got[9:0]);
    read_reg(RegSlot, got);
    check_field("slot_ticks", SlotRst, got[7:0]);
    read_reg(RegWriteOneLow, got);
    check_field("write_one_low_ticks", WriteOneLowRst, got[3:0]);
    read_reg(RegReadLow, got);
    check_field("read_low_ticks", ReadLowRst, got[3:0]);
    drain_results();
  endtask

  // All durations zero: writes end on their command word, the presence sample
  // still takes a tick, every read bit takes exactly one tick.
  task automatic test_zero_timing();
    logic [7:0] pattern;
    pattern = 8'hA5;
    program_timing('0);
    // Spare addresses must not alias onto a timing register.
    write_reg(RegSpareA, '1);
    write_reg(RegSpareB, 32'h0000_5A5A);
    // Idle ticks release the bus; tx_byte is ignored on ticks.
    send_word(FuncTick, 8'hFF, 1'b1);
    send_word(FuncTick, 8'h00, 1'b0);
    // Write extremes; line_level is ignored on commands.
    send_word(FuncWrite, 8'hFF, 1'b1);
    send_word(FuncWrite, 8'h00, 1'b0);
    // Reset with a device answering, then with nobody there.
    send_word(FuncReset, 8'h5A, 1'b1);
    send_word(FuncTick, 8'h00, 1'b0);
    send_word(FuncReset, 8'h00, 1'b0);
    send_word(FuncTick, 8'hFF, 1'b1);
    // Read a known pattern; bounce every command kind and pause midway.
    send_word(FuncRead, 8'hFF, 1'b1);
    for (int i = 0; i < 8; i++) begin
      send_word(FuncTick, 8'($urandom), pattern[i]);
      case (i)
        0: send_word(FuncReset, 8'h00, 1'b0);
        1: send_word(FuncWrite, 8'hFF, 1'b1);
        2: send_word(FuncRead, 8'h00, 1'b0);
        3: drain_results();
        default: ;
      endcase
    end
    drain_results();
  endtask

  // All ones into every register reads back clipped to each field width; then
  // one reset at the longest presence wait and one write at the longest low time.
  task automatic test_extreme_timing();
    logic [DataW-1:0] got;
    write_reg(RegResetLow,     '1);
    write_reg(RegPresenceWait, '1);
    write_reg(RegResetTail,    '1);
    write_reg(RegSlot,         '1);
    write_reg(RegWriteOneLow,  '1);
    write_reg(RegReadLow,      '1);
    read_reg(RegResetLow, got);
    check_field("reset_low_ticks", 10'h3FF, got);
    read_reg(RegPresenceWait, got);
    check_field("presence_wait_ticks", 8'hFF, got);
    read_reg(RegResetTail, got);
    check_field("reset_tail_ticks", 10'h3FF, got);
    read_reg(RegSlot, got);
    check_field("slot_ticks", 8'hFF, got);
    read_reg(RegWriteOneLow, got);
    check_field("write_one_low_ticks", 4'hF, got);
    read_reg(RegReadLow, got);
    check_field("read_low_ticks", 4'hF, got);
    program_timing('{reset_low: '0, presence_wait: 8'hFF, reset_tail: '0,
                     slot: '0, write_one_low: 4'hF, read_low: 4'hF});
    sender_steady = 1'b1;
    run_operation(FuncReset, 1'b1);
    sender_steady = 1'b0;
    sink_steady   = 1'b1;
    run_operation(FuncWrite, 1'b1);
    sink_steady   = 1'b0;
    drain_results();
  endtask

  // Two rounds of short random timing, each filled with back-to-back
  // operations, idle ticks between them and noise inside them.
  task automatic test_random_sequences();
    cfg_t        c;
    int unsigned goal;
    for (int round = 0; round < 2; round++) begin
      drain_results();
      c.reset_low     = 10'(short_count(12));
      c.presence_wait = 8'(short_count(8));
      c.reset_tail    = 10'(short_count(12));
      c.slot          = 8'(short_count(10));
      c.write_one_low = 4'(short_count(15));
      c.read_low      = 4'(short_count(15));
      program_timing(c);
      goal = useful_items + 100;
      while (useful_items < goal) begin
        sender_steady = ($urandom_range(0, 3) == 0);
        sink_steady   = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 2)) send_word(FuncTick, 8'($urandom), 1'($urandom));
        run_operation(func_e'(2'($urandom_range(1, 3))), 1'b1);
      end
    end
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    drain_results();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    cmd_if.valid      <= 1'b0;
    cmd_if.func       <= FuncTick;
    cmd_if.tx_byte    <= '0;
    cmd_if.line_level <= 1'b0;
    faults       = 0;
    useful_items = 0;
    clear_sequencer();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_zero_timing();
    test_extreme_timing();
    test_random_sequences();

    // Let any stray word surface before the verdict.
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (faults == 0 && bus_words_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/owbm_pkg.sv
rtl/owbm_if.sv
rtl/owbm_regs.sv
rtl/owbm_core.sv
rtl/one_wire_bus_master.sv
test/testbench.sv
